// ===== sv/qvr_pkg.sv =====
// Shared constants for the quaternion vector rotation block.
package qvr_pkg;

  // Default width of every quaternion, vector and result component.
  localparam int COMPONENT_BITS_DEF = 16;
  // Default fraction bits kept in the fixed-point reciprocal of the norm.
  localparam int RECIP_FRAC_BITS_DEF = 30;
  // Quotient bits resolved by one register stage of the reciprocal divider.
  localparam int DIV_STEP = 2;

endpackage

// ===== sv/qvr_if.sv =====
// Valid/ready channel interfaces for the input beat and the result beat.
interface qvr_in_if #(
  parameter int B = qvr_pkg::COMPONENT_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [B-1:0] quat_w;
  logic signed [B-1:0] quat_x;
  logic signed [B-1:0] quat_y;
  logic signed [B-1:0] quat_z;
  logic signed [B-1:0] vec_x;
  logic signed [B-1:0] vec_y;
  logic signed [B-1:0] vec_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface qvr_out_if #(
  parameter int B = qvr_pkg::COMPONENT_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [B-1:0] out_x;
  logic signed [B-1:0] out_y;
  logic signed [B-1:0] out_z;
  logic                zero_quat;
  logic                saturated;

  modport source (output valid, out_x, out_y, out_z, zero_quat, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, zero_quat, saturated, output ready);
endinterface

// ===== sv/qvr_matrix.sv =====
// Quadratic terms, unscaled rotation matrix, matrix-vector product and alignment delay.
module qvr_matrix #(
  parameter int COMPONENT_BITS  = qvr_pkg::COMPONENT_BITS_DEF,
  parameter int RECIP_FRAC_BITS = qvr_pkg::RECIP_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic [((RECIP_FRAC_BITS + 2 + qvr_pkg::DIV_STEP - 1) / qvr_pkg::DIV_STEP) + 2:0] en,
  input  logic signed [COMPONENT_BITS-1:0]     quat_w,
  input  logic signed [COMPONENT_BITS-1:0]     quat_x,
  input  logic signed [COMPONENT_BITS-1:0]     quat_y,
  input  logic signed [COMPONENT_BITS-1:0]     quat_z,
  input  logic signed [COMPONENT_BITS-1:0]     vec_x,
  input  logic signed [COMPONENT_BITS-1:0]     vec_y,
  input  logic signed [COMPONENT_BITS-1:0]     vec_z,
  output logic [2*COMPONENT_BITS:0]            norm_o,
  output logic [3*COMPONENT_BITS:0]            mag_o [3],
  output logic                                 neg_o [3]
);

  localparam int B       = COMPONENT_BITS;
  localparam int QW      = RECIP_FRAC_BITS + 2;
  localparam int DIV_STG = (QW + qvr_pkg::DIV_STEP - 1) / qvr_pkg::DIV_STEP;
  localparam int DLY     = DIV_STG - 2;
  localparam int PW      = 2 * B;
  localparam int NW      = 2 * B + 1;
  localparam int EW      = 2 * B + 2;
  localparam int AW      = 3 * B + 2;
  localparam int MW      = 3 * B + 1;

  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [B-1:0]  v0_r [3];
  logic signed [B-1:0]  v1_r [3];
  logic signed [EW-1:0] e_r [3][3];
  logic [NW-1:0]        norm_r;
  logic signed [AW-1:0] ev_r [3][3];
  logic signed [AW-1:0] acc_r [3];
  logic [MW-1:0]        mag_r [DLY+1][3];
  logic                 neg_r [DLY+1][3];

  // Ten quadratic terms of the quaternion.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ww_r    <= PW'(quat_w) * PW'(quat_w);
      xx_r    <= PW'(quat_x) * PW'(quat_x);
      yy_r    <= PW'(quat_y) * PW'(quat_y);
      zz_r    <= PW'(quat_z) * PW'(quat_z);
      xy_r    <= PW'(quat_x) * PW'(quat_y);
      wz_r    <= PW'(quat_w) * PW'(quat_z);
      xz_r    <= PW'(quat_x) * PW'(quat_z);
      wy_r    <= PW'(quat_w) * PW'(quat_y);
      yz_r    <= PW'(quat_y) * PW'(quat_z);
      wx_r    <= PW'(quat_w) * PW'(quat_x);
      v0_r[0] <= vec_x;
      v0_r[1] <= vec_y;
      v0_r[2] <= vec_z;
    end
  end

  // Matrix entries in the frame convention, scaled by the squared norm.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      e_r[0][0] <= EW'(ww_r) + EW'(xx_r) - EW'(yy_r) - EW'(zz_r);
      e_r[0][1] <= (EW'(xy_r) + EW'(wz_r)) <<< 1;
      e_r[0][2] <= (EW'(xz_r) - EW'(wy_r)) <<< 1;
      e_r[1][0] <= (EW'(xy_r) - EW'(wz_r)) <<< 1;
      e_r[1][1] <= EW'(ww_r) - EW'(xx_r) + EW'(yy_r) - EW'(zz_r);
      e_r[1][2] <= (EW'(yz_r) + EW'(wx_r)) <<< 1;
      e_r[2][0] <= (EW'(xz_r) + EW'(wy_r)) <<< 1;
      e_r[2][1] <= (EW'(yz_r) - EW'(wx_r)) <<< 1;
      e_r[2][2] <= EW'(ww_r) - EW'(xx_r) - EW'(yy_r) + EW'(zz_r);
      norm_r    <= NW'($unsigned(ww_r)) + NW'($unsigned(xx_r))
                 + NW'($unsigned(yy_r)) + NW'($unsigned(zz_r));
      v1_r      <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          ev_r[r][c] <= AW'(e_r[r][c]) * AW'(v1_r[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        acc_r[r] <= ev_r[r][0] + ev_r[r][1] + ev_r[r][2];
      end
    end
  end

  // Sign and magnitude, then held until the reciprocal is ready.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int r = 0; r < 3; r++) begin
        neg_r[0][r] <= acc_r[r][AW-1];
        mag_r[0][r] <= MW'(acc_r[r][AW-1] ? -acc_r[r] : acc_r[r]);
      end
    end
  end

  for (genvar d = 1; d <= DLY; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[4+d]) begin
        neg_r[d] <= neg_r[d-1];
        mag_r[d] <= mag_r[d-1];
      end
    end
  end

  assign norm_o = norm_r;
  assign mag_o  = mag_r[DLY];
  assign neg_o  = neg_r[DLY];

endmodule

// ===== sv/qvr_recip.sv =====
// Norm normalization and pipelined restoring divider for the reciprocal of the norm.
module qvr_recip #(
  parameter int COMPONENT_BITS  = qvr_pkg::COMPONENT_BITS_DEF,
  parameter int RECIP_FRAC_BITS = qvr_pkg::RECIP_FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic [(RECIP_FRAC_BITS + 2 + qvr_pkg::DIV_STEP - 1) / qvr_pkg::DIV_STEP:0] en,
  input  logic [2*COMPONENT_BITS:0]                  norm_i,
  output logic [RECIP_FRAC_BITS+1:0]                 recip_o,
  output logic [$clog2(2*COMPONENT_BITS+1)-1:0]      shift_o,
  output logic                                       zero_o
);

  localparam int B       = COMPONENT_BITS;
  localparam int QW      = RECIP_FRAC_BITS + 2;
  localparam int DIV_STG = (QW + qvr_pkg::DIV_STEP - 1) / qvr_pkg::DIV_STEP;
  localparam int NW      = 2 * B + 1;
  localparam int RW      = 2 * B + 2;
  localparam int SW      = $clog2(2 * B + 1);

  logic [NW-1:0] m_r   [DIV_STG+1];
  logic [SW-1:0] s_r   [DIV_STG+1];
  logic          zq_r  [DIV_STG+1];
  logic [RW-1:0] rem_r [1:DIV_STG];
  logic [QW-1:0] q_r   [1:DIV_STG];
  logic [NW-1:0] m_c;
  logic [SW-1:0] s_c;

  // Binary search for the left shift that puts the top bit of the norm at bit 2B.
  always_comb begin
    m_c = norm_i;
    s_c = '0;
    for (int j = SW - 1; j >= 0; j--) begin
      if ((m_c >> (2 * B - (1 << j) + 1)) == '0) begin
        m_c = m_c << (1 << j);
        s_c = s_c + SW'(1 << j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r[0]  <= m_c;
      s_r[0]  <= s_c;
      zq_r[0] <= (norm_i == '0);
    end
  end

  for (genvar d = 1; d <= DIV_STG; d++) begin : g_div
    logic [RW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [RW-1:0] rem_c;
    logic [QW-1:0] q_c;

    if (d == 1) begin : g_first
      // The dividend is a single one bit; the first step shifts it up to bit 2B.
      assign rem_in = RW'(1) << (2 * B - 1);
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[d-1];
      assign q_in   = q_r[d-1];
    end

    always_comb begin
      rem_c = rem_in;
      q_c   = q_in;
      for (int t = 0; t < qvr_pkg::DIV_STEP; t++) begin
        if ((d - 1) * qvr_pkg::DIV_STEP + t < QW) begin
          rem_c = rem_c << 1;
          if (rem_c >= RW'(m_r[d-1])) begin
            rem_c = rem_c - RW'(m_r[d-1]);
            q_c   = {q_c[QW-2:0], 1'b1};
          end else begin
            q_c   = {q_c[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[d]) begin
        rem_r[d] <= rem_c;
        q_r[d]   <= q_c;
        m_r[d]   <= m_r[d-1];
        s_r[d]   <= s_r[d-1];
        zq_r[d]  <= zq_r[d-1];
      end
    end
  end

  assign recip_o = q_r[DIV_STG];
  assign shift_o = s_r[DIV_STG];
  assign zero_o  = zq_r[DIV_STG];

endmodule

// ===== sv/qvr_scale.sv =====
// Reciprocal multiply, rounding shift, saturation and sign for the three components.
module qvr_scale #(
  parameter int COMPONENT_BITS  = qvr_pkg::COMPONENT_BITS_DEF,
  parameter int RECIP_FRAC_BITS = qvr_pkg::RECIP_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic [2:0]                            en,
  input  logic [3*COMPONENT_BITS:0]             mag_i [3],
  input  logic                                  neg_i [3],
  input  logic [RECIP_FRAC_BITS+1:0]            recip_i,
  input  logic [$clog2(2*COMPONENT_BITS+1)-1:0] shift_i,
  input  logic                                  zero_i,
  output logic signed [COMPONENT_BITS-1:0]      res_o [3],
  output logic                                  zero_o,
  output logic                                  sat_o
);

  localparam int B    = COMPONENT_BITS;
  localparam int QW   = RECIP_FRAC_BITS + 2;
  localparam int MW   = 3 * B + 1;
  localparam int LOW  = (MW + 1) / 2;
  localparam int HIW  = MW - LOW;
  localparam int SUMW = MW + QW + 1;
  localparam int K    = RECIP_FRAC_BITS + 2 * B + 1;
  localparam int SHW  = $clog2(K + 1);

  logic [LOW+QW-1:0]   pp_lo_r [3];
  logic [HIW+QW-1:0]   pp_hi_r [3];
  logic                neg_a_r [3];
  logic                neg_b_r [3];
  logic [SHW-1:0]      sh_a_r, sh_b_r;
  logic                zq_a_r, zq_b_r;
  logic [SUMW-1:0]     sum_r [3];
  logic [SUMW-1:0]     rnd_c;
  logic [SUMW-1:0]     quo_c [3];
  logic [SUMW-1:0]     lim_c [3];
  logic [B-1:0]        val_c [3];
  logic                sat_c [3];
  logic signed [B-1:0] res_r [3];
  logic                zero_r;
  logic                sat_r;

  // Two partial products per component keep each multiplier near 32 bits.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        pp_lo_r[r] <= (LOW + QW)'(mag_i[r][LOW-1:0]) * (LOW + QW)'(recip_i);
        pp_hi_r[r] <= (HIW + QW)'(mag_i[r][MW-1:LOW]) * (HIW + QW)'(recip_i);
      end
      neg_a_r <= neg_i;
      sh_a_r  <= SHW'(K) - SHW'(shift_i);
      zq_a_r  <= zero_i;
    end
  end

  // Half of the final weight is added so the shift rounds half up.
  assign rnd_c = SUMW'(1) << (sh_a_r - SHW'(1));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= SUMW'(pp_lo_r[r]) + (SUMW'(pp_hi_r[r]) << LOW) + rnd_c;
      end
      neg_b_r <= neg_a_r;
      sh_b_r  <= sh_a_r;
      zq_b_r  <= zq_a_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      quo_c[r] = sum_r[r] >> sh_b_r;
      lim_c[r] = neg_b_r[r] ? (SUMW'(1) << (B - 1)) : ((SUMW'(1) << (B - 1)) - SUMW'(1));
      sat_c[r] = quo_c[r] > lim_c[r];
      val_c[r] = sat_c[r] ? lim_c[r][B-1:0] : quo_c[r][B-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        res_r[r] <= zq_b_r ? '0 : (neg_b_r[r] ? -val_c[r] : val_c[r]);
      end
      zero_r <= zq_b_r;
      sat_r  <= !zq_b_r && (sat_c[0] || sat_c[1] || sat_c[2]);
    end
  end

  assign res_o  = res_r;
  assign zero_o = zero_r;
  assign sat_o  = sat_r;

endmodule

// ===== sv/quaternion_vector_rotate.sv =====
// Top level of the quaternion vector rotation pipeline.
//
// Rotates a three-vector by the direction cosine matrix (frame convention) of a
// quaternion of any nonzero length. Each input beat on in_ch carries the
// quaternion and the vector as signed components; each result beat on out_ch
// carries the rotated components, rounded to nearest and saturated, a flag for
// an all-zero quaternion (vector forced to zero) and a flag for any clipping.
// Both channels use valid/ready; a beat moves on a clock edge where both are high.
//
// Every beat gives exactly one result beat, in order. The pipeline holds
// 6 + ceil((RECIP_FRAC_BITS + 2) / 2) register stages, 22 with the defaults. The
// length is set by the reciprocal divider, which resolves two quotient bits a
// stage. A new beat is taken every cycle while results drain.
//
// Each stage has its own valid bit and advances when it is empty or the next
// stage advances. When the receiver holds ready low, the last stage keeps its
// result and the empty stages behind it still fill, so in_ch.ready drops only
// when every stage holds a beat. Synchronous reset clears all valid bits; the
// data registers are not reset.
module quaternion_vector_rotate #(
  parameter int COMPONENT_BITS  = qvr_pkg::COMPONENT_BITS_DEF,
  parameter int RECIP_FRAC_BITS = qvr_pkg::RECIP_FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  qvr_in_if.sink     in_ch,
  qvr_out_if.source  out_ch
);

  localparam int B       = COMPONENT_BITS;
  localparam int QW      = RECIP_FRAC_BITS + 2;
  localparam int DIV_STG = (QW + qvr_pkg::DIV_STEP - 1) / qvr_pkg::DIV_STEP;
  localparam int NST     = DIV_STG + 6;
  localparam int SW      = $clog2(2 * B + 1);
  localparam int CW      = $clog2(NST + 1);

  logic [NST-1:0]        v_r, v_nxt;
  logic [NST:0]          stg_en;
  logic [2*B:0]          norm_w;
  logic [3*B:0]          mag_w [3];
  logic                  neg_w [3];
  logic [QW-1:0]         recip_w;
  logic [SW-1:0]         shift_w;
  logic                  zero_w;
  logic signed [B-1:0]   res_w [3];

  // A stage may load when it is empty or its contents move on this edge.
  always_comb begin
    stg_en[NST] = out_ch.ready;
    for (int i = NST - 1; i >= 0; i--) begin
      stg_en[i] = !v_r[i] || stg_en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = stg_en[0] ? in_ch.valid : v_r[0];
    for (int i = 1; i < NST; i++) begin
      v_nxt[i] = stg_en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = stg_en[0];

  qvr_matrix #(
    .COMPONENT_BITS  (COMPONENT_BITS),
    .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
  ) u_matrix (
    .clk    (clk),
    .en     (stg_en[DIV_STG+2:0]),
    .quat_w (in_ch.quat_w),
    .quat_x (in_ch.quat_x),
    .quat_y (in_ch.quat_y),
    .quat_z (in_ch.quat_z),
    .vec_x  (in_ch.vec_x),
    .vec_y  (in_ch.vec_y),
    .vec_z  (in_ch.vec_z),
    .norm_o (norm_w),
    .mag_o  (mag_w),
    .neg_o  (neg_w)
  );

  qvr_recip #(
    .COMPONENT_BITS  (COMPONENT_BITS),
    .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
  ) u_recip (
    .clk     (clk),
    .en      (stg_en[DIV_STG+2:2]),
    .norm_i  (norm_w),
    .recip_o (recip_w),
    .shift_o (shift_w),
    .zero_o  (zero_w)
  );

  qvr_scale #(
    .COMPONENT_BITS  (COMPONENT_BITS),
    .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
  ) u_scale (
    .clk     (clk),
    .en      (stg_en[NST-1:NST-3]),
    .mag_i   (mag_w),
    .neg_i   (neg_w),
    .recip_i (recip_w),
    .shift_i (shift_w),
    .zero_i  (zero_w),
    .res_o   (res_w),
    .zero_o  (out_ch.zero_quat),
    .sat_o   (out_ch.saturated)
  );

  assign out_ch.valid = v_r[NST-1];
  assign out_ch.out_x = res_w[0];
  assign out_ch.out_y = res_w[1];
  assign out_ch.out_z = res_w[2];

  // The number of beats in flight changes only by what enters and leaves.
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (CW'($countones(v_r)) == CW'($past($countones(v_r)))
              + CW'($past(in_ch.valid && in_ch.ready))
              - CW'($past(out_ch.valid && out_ch.ready))))
    else $error("beat count through the pipeline is not conserved");

  // Input back-pressure only when no stage is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled while a pipeline stage is empty");

  // An all-zero quaternion yields a zero vector and no clipping.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_quat |->
      out_ch.out_x == '0 && out_ch.out_y == '0 && out_ch.out_z == '0 && !out_ch.saturated)
    else $error("zero quaternion result is not cleared");

  // A clipped result shows at least one component at a limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      out_ch.out_x == {1'b0, {(B-1){1'b1}}} || out_ch.out_x == {1'b1, {(B-1){1'b0}}} ||
      out_ch.out_y == {1'b0, {(B-1){1'b1}}} || out_ch.out_y == {1'b1, {(B-1){1'b0}}} ||
      out_ch.out_z == {1'b0, {(B-1){1'b1}}} || out_ch.out_z == {1'b1, {(B-1){1'b0}}})
    else $error("saturated flag without a component at a limit");

endmodule
